/* src/u8d_pkg.sv */
// shared types and constants of the utf-8 stream decoder
`timescale 1ns / 1ps
package u8d_pkg;

  localparam int CMD_DEPTH = 4;

  localparam int CP_W   = 21;
  localparam int USED_W = 3;

  localparam logic [CP_W-1:0]   SUBST_CP   = 21'd63;
  localparam logic [USED_W-1:0] SUBST_USED = 3'd1;

  // one decode command: leading substitutions, an optional main result,
  // then trailing substitutions up to total
  typedef struct packed {
    logic [1:0]        pre;
    logic              main_valid;
    logic [CP_W-1:0]   main_cp;
    logic [USED_W-1:0] main_used;
    logic [2:0]        total;
    logic              eot;
  } cmd_t;

endpackage

/* src/u8d_byte_if.sv */
// byte input channel
`timescale 1ns / 1ps
interface u8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_text;

  modport source (output valid, output byte_in, output end_of_text, input ready);
  modport sink (input valid, input byte_in, input end_of_text, output ready);
endinterface

/* src/u8d_cp_if.sv */
// codepoint output channel
`timescale 1ns / 1ps
interface u8d_cp_if;
  import u8d_pkg::*;
  logic              valid;
  logic              ready;
  logic [CP_W-1:0]   codepoint;
  logic [USED_W-1:0] bytes_used;
  logic              last_of_run;
  logic              text_done;

  modport source (output valid, output codepoint, output bytes_used,
                  output last_of_run, output text_done, input ready);
  modport sink (input valid, input codepoint, input bytes_used,
                input last_of_run, input text_done, output ready);
endinterface

/* src/u8d_front.sv */
// front end: byte classification, sequence buffering and command build
`timescale 1ns / 1ps
module u8d_front
  import u8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  u8d_byte_if.sink  bytes,
  input  logic      full,
  output logic      push,
  output cmd_t      cmd
);

  logic [7:0] pend [3];
  logic [1:0] count, count_next;
  logic [2:0] exp_len, exp_len_next;

  logic       accept;
  logic [7:0] b;
  logic       is_cont, is_ascii, is_lead;
  logic [2:0] lead_len;
  logic       buf_wr;
  logic [1:0] buf_idx;
  logic [CP_W-1:0] dec_cp;

  assign bytes.ready = !full;
  assign accept      = bytes.valid && bytes.ready;
  assign b           = bytes.byte_in;

  always_comb begin
    is_cont  = (b[7:6] == 2'b10);
    is_ascii = !b[7];
    lead_len = 3'd0;
    if (b[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end
    is_lead = (lead_len != 3'd0);
  end

  always_comb begin
    case (exp_len)
      3'd2:    dec_cp = {10'd0, pend[0][4:0], b[5:0]};
      3'd3:    dec_cp = {5'd0, pend[0][3:0], pend[1][5:0], b[5:0]};
      default: dec_cp = {pend[0][2:0], pend[1][5:0], pend[2][5:0], b[5:0]};
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.eot        = bytes.end_of_text;
    count_next     = count;
    exp_len_next   = exp_len;
    buf_wr         = 1'b0;
    buf_idx        = count;
    if (count == 2'd0 || !is_cont) begin
      // fresh start, after flushing whatever was pending
      cmd.pre   = count;
      cmd.total = {1'b0, count};
      if (is_ascii || !is_lead) begin
        cmd.main_valid = 1'b1;
        cmd.main_cp    = is_ascii ? {13'd0, b} : SUBST_CP;
        cmd.main_used  = SUBST_USED;
        cmd.total      = {1'b0, count} + 3'd1;
        count_next     = 2'd0;
        exp_len_next   = 3'd0;
      end else begin
        buf_wr       = 1'b1;
        buf_idx      = 2'd0;
        count_next   = 2'd1;
        exp_len_next = lead_len;
        if (bytes.end_of_text) begin
          cmd.total    = {1'b0, count} + 3'd1;
          count_next   = 2'd0;
          exp_len_next = 3'd0;
        end
      end
    end else if (({1'b0, count} + 3'd1) >= exp_len) begin
      cmd.main_valid = 1'b1;
      cmd.main_cp    = dec_cp;
      cmd.main_used  = exp_len;
      cmd.total      = 3'd1;
      count_next     = 2'd0;
      exp_len_next   = 3'd0;
    end else begin
      buf_wr     = 1'b1;
      count_next = count + 2'd1;
      if (bytes.end_of_text) begin
        // truncated at end of text: one substitution per buffered byte
        cmd.total    = {1'b0, count} + 3'd1;
        count_next   = 2'd0;
        exp_len_next = 3'd0;
      end
    end
    push = accept && (cmd.total != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= 2'd0;
      exp_len <= 3'd0;
    end else if (accept) begin
      count   <= count_next;
      exp_len <= exp_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && buf_wr) begin
      pend[buf_idx] <= b;
    end
  end

`ifndef SYNTHESIS
  a_pending_has_length: assert property (@(posedge clk) disable iff (rst)
    count != 2'd0 |-> (exp_len >= 3'd2 && {1'b0, count} < exp_len))
    else $error("pending bytes without a matching sequence length");
`endif

endmodule

/* src/u8d_cmd_fifo.sv */
// command queue between front and back end
`timescale 1ns / 1ps
module u8d_cmd_fifo
  import u8d_pkg::*;
#(
  parameter int Depth = CMD_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne = PtrW'(1);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] used;

  assign full  = (used == DepthCnt);
  assign empty = (used == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrOne;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrOne;
      end
      if (push && !pop) begin
        used <= used + CntOne;
      end else if (pop && !push) begin
        used <= used - CntOne;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("command queue read while empty");
`endif

endmodule

/* src/u8d_back.sv */
// back end: expands commands into codepoint results
`timescale 1ns / 1ps
module u8d_back
  import u8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      empty,
  input  cmd_t      head,
  output logic      pop,
  u8d_cp_if.source  codepoints
);

  logic [1:0]        idx;
  logic              advance;
  logic              is_last;
  logic              is_main;
  logic [CP_W-1:0]   sel_cp;
  logic [USED_W-1:0] sel_used;

  always_comb begin
    advance  = !empty && (!codepoints.valid || codepoints.ready);
    is_last  = (({1'b0, idx} + 3'd1) == head.total);
    is_main  = head.main_valid && (idx == head.pre);
    sel_cp   = is_main ? head.main_cp : SUBST_CP;
    sel_used = is_main ? head.main_used : SUBST_USED;
    pop      = advance && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      codepoints.valid <= 1'b0;
      idx              <= 2'd0;
    end else if (advance) begin
      codepoints.valid <= 1'b1;
      idx              <= is_last ? 2'd0 : idx + 2'd1;
    end else if (codepoints.ready) begin
      codepoints.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      codepoints.codepoint   <= sel_cp;
      codepoints.bytes_used  <= sel_used;
      codepoints.last_of_run <= is_last;
      codepoints.text_done   <= is_last && head.eot;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ({1'b0, idx} < head.total))
    else $error("result index beyond command length");
  a_idx_idle_zero: assert property (@(posedge clk) disable iff (rst)
    empty |-> idx == 2'd0)
    else $error("result index left mid-command with no command queued");
`endif

endmodule

/* src/utf8_stream_decoder_core.sv */
// streaming utf-8 decoder: one byte request in, zero to four codepoint requests out
// a byte's results are registered into the command queue, then into the output register
// throughput: one byte per cycle while each byte yields at most one result and output is taken;
//   a multi-result byte holds the result stage while the back end emits them one per cycle
// the command queue (CmdDepth entries) absorbs result bursts and output stalls
// reset (rst, synchronous): clears sequence state, queue and output valid; byte buffer is not reset
`timescale 1ns / 1ps
module utf8_stream_decoder_core
  import u8d_pkg::*;
#(
  parameter int CmdDepth = CMD_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  u8d_byte_if.sink  bytes,
  u8d_cp_if.source  codepoints
);

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic full;

  // queue to back
  logic pop;
  logic empty;
  cmd_t head;

  // front end classifies each byte, buffers multi-byte sequences and
  // turns every byte that has results into one command
  u8d_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .full  (full),
    .push  (push),
    .cmd   (push_cmd)
  );

  // queue lets the byte side keep going while results drain
  u8d_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  // back end walks each command, one result per cycle while not stalled, into the output register
  u8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .codepoints (codepoints)
  );

`ifndef SYNTHESIS
  a_back_pressure_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !bytes.ready |-> full)
    else $error("byte request stalled with room in the command queue");
`endif

endmodule

/* verif/tb.sv */
// self-checking testbench of the utf-8 stream decoder: directed and random byte streams
`timescale 1ns / 1ps
module tb;
  import u8d_pkg::*;

  // generous cycle budget for the whole run
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic [USED_W-1:0] used;
    logic              last;
    logic              done;
  } cp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  u8d_byte_if byte_ch ();
  u8d_cp_if   cp_ch ();

  utf8_stream_decoder_core DUT (
    .clk        (clk),
    .rst        (rst),
    .bytes      (byte_ch),
    .codepoints (cp_ch)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // decoder shadow state and expected codepoints
  // ------------------------------------------------------------------
  logic [7:0]  seq_buf [3];
  int          seq_cnt;
  int          seq_len;
  cp_result_t  step_out [$];
  cp_result_t  cp_expect [$];
  int          mismatches = 0;
  int          cycles = 0;

  function automatic void queue_result(input logic [CP_W-1:0] cp, input logic [USED_W-1:0] used);
    cp_result_t r;
    r.cp   = cp;
    r.used = used;
    r.last = 1'b0;
    r.done = 1'b0;
    step_out.push_back(r);
  endfunction

  // every buffered byte of a dead sequence turns into its own '?'
  function automatic void flush_seq();
    for (int i = 0; i < seq_cnt; i++) queue_result(SUBST_CP, SUBST_USED);
    seq_cnt = 0;
    seq_len = 0;
  endfunction

  // a byte seen with nothing pending: ascii, a lead, or garbage
  function automatic void begin_byte(input logic [7:0] b);
    int len;
    len = 0;
    casez (b)
      8'b0???????: begin
        queue_result({13'd0, b}, 3'd1);
        return;
      end
      8'b110?????: len = 2;
      8'b1110????: len = 3;
      8'b11110???: len = 4;
      default: len = 0;
    endcase
    if (len == 0) begin
      queue_result(SUBST_CP, SUBST_USED);
    end else begin
      seq_buf[0] = b;
      seq_cnt    = 1;
      seq_len    = len;
    end
  endfunction

  // one accepted byte request -> zero or more expected codepoints
  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    logic [CP_W-1:0] cp;
    cp_result_t      tail;
    step_out.delete();
    if (seq_cnt == 0) begin
      begin_byte(b);
    end else if (b[7:6] == 2'b10) begin
      if (seq_cnt + 1 >= seq_len) begin
        case (seq_len)
          2:       cp = {10'd0, seq_buf[0][4:0], b[5:0]};
          3:       cp = {5'd0, seq_buf[0][3:0], seq_buf[1][5:0], b[5:0]};
          default: cp = {seq_buf[0][2:0], seq_buf[1][5:0], seq_buf[2][5:0], b[5:0]};
        endcase
        queue_result(cp, USED_W'(seq_len));
        seq_cnt = 0;
        seq_len = 0;
      end else if (seq_cnt < 3) begin
        seq_buf[seq_cnt] = b;
        seq_cnt++;
      end
    end else begin
      // broken sequence: flush, then look at the breaking byte afresh
      flush_seq();
      begin_byte(b);
    end
    if (eot) flush_seq();
    if (step_out.size() > 0) begin
      tail      = step_out[$];
      tail.last = 1'b1;
      tail.done = eot;
      step_out[$] = tail;
    end
    foreach (step_out[i]) cp_expect.push_back(step_out[i]);
  endfunction

  function automatic void check_field(input string name, input logic [CP_W-1:0] want,
                                      input logic [CP_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // ------------------------------------------------------------------
  // monitor: check results first, then predict from the byte taken at
  // the same edge, so ordering inside a time step never matters
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    cp_result_t want;
    if (rst) begin
      seq_cnt = 0;
      seq_len = 0;
      cp_expect.delete();
    end else begin
      if (cp_ch.valid && cp_ch.ready) begin
        if (cp_expect.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected codepoint, expected none actual %0h", $time,
                   cp_ch.codepoint);
        end else begin
          want = cp_expect.pop_front();
          check_field("codepoint", want.cp, cp_ch.codepoint);
          check_field("bytes_used", CP_W'(want.used), CP_W'(cp_ch.bytes_used));
          check_field("last_of_run", CP_W'(want.last), CP_W'(cp_ch.last_of_run));
          check_field("text_done", CP_W'(want.done), CP_W'(cp_ch.text_done));
        end
      end
      if (byte_ch.valid && byte_ch.ready) decode_byte(byte_ch.byte_in, byte_ch.end_of_text);
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // receiver: rotating stall pattern, reshuffled at random whenever pat_age wraps; a long
  // hold-off is asked for by bumping hold_asks
  // ------------------------------------------------------------------
  logic [15:0] stall_pat = 16'hffff;
  int          pat_age = 0;
  int          hold_left = 0;
  int          hold_asks = 0;
  int          hold_seen = 0;

  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      cp_ch.ready <= 1'b0;
    end else begin
      cp_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      pat_age++;
      if (pat_age == 32) begin
        pat_age = 0;
        case ($urandom_range(0, 3))
          0:       stall_pat = 16'hffff;                      // no stalls
          1:       stall_pat = 16'($urandom) | 16'h7777;      // light stalls
          2:       stall_pat = 16'($urandom);                 // heavy stalls
          default: stall_pat = 16'($urandom) & 16'h00ff;      // long gaps
        endcase
        if (stall_pat == 16'd0) stall_pat = 16'h0001;
      end
    end
  end

  // ------------------------------------------------------------------
  // sender: bursts of random length with random gaps between them
  // ------------------------------------------------------------------
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int bytes_sent = 0;

  // valid held low, data scrambled so the block must ignore it
  task automatic sender_idle(input int n);
    repeat (n) begin
      @(negedge clk);
      byte_ch.valid       <= 1'b0;
      byte_ch.byte_in     <= 8'($urandom);
      byte_ch.end_of_text <= 1'($urandom);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) sender_idle(gap);
    end
    burst_left--;
    @(negedge clk);
    byte_ch.valid       <= 1'b1;
    byte_ch.byte_in     <= b;
    byte_ch.end_of_text <= eot;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drain_results();
    sender_idle(1);
    while (cp_expect.size() != 0) @(posedge clk);
  endtask

  // one character of random content; keep < len-1 leaves it broken
  task automatic send_char(input int len, input int keep);
    logic [7:0] lead;
    case (len)
      1:       lead = {1'b0, 7'($urandom)};
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    send_byte(lead, $urandom_range(0, 24) == 0);
    for (int i = 0; i < keep && i < len - 1; i++)
      send_byte({2'b10, 6'($urandom)}, $urandom_range(0, 24) == 0);
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  task automatic test_ascii_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
  endtask

  // shortest and longest forms, overlong zero accepted as is
  task automatic test_sequences();
    send_byte(8'hc0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hdf, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hef, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hf7, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b0);
  endtask

  // stray continuation and out-of-range lead with nothing pending
  task automatic test_invalid_leads();
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
  endtask

  task automatic test_broken_sequences();
    // three buffered bytes broken by ascii: three '?' then the ascii
    send_byte(8'hf0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
    // a lead broken by a lead that then completes
    send_byte(8'hc3, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'ha9, 1'b0);
  endtask

  task automatic test_end_flush();
    // truncated sequence flushed by the end flag
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'h41, 1'b1);
  endtask

  // mostly well-formed text, some broken characters and raw noise
  task automatic test_random_text(input int n_bytes);
    int target;
    int len;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 29) == 0) gaps_on = $urandom_range(0, 2) != 0;
      len = $urandom_range(1, 4);
      case ($urandom_range(0, 9))
        0:       send_byte(8'($urandom), $urandom_range(0, 24) == 0);
        1:       send_char(len, $urandom_range(0, 2));
        default: send_char(len, 3);
      endcase
    end
    gaps_on = 1'b1;
  endtask

  // receiver holds off while the sender streams without gaps, so the
  // command queue fills and the byte input must stall
  task automatic test_output_hold(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    gaps_on = 1'b0;
    hold_asks++;
    while (bytes_sent < target) send_char($urandom_range(1, 4), $urandom_range(0, 3));
    gaps_on = 1'b1;
  endtask

  // sender stops until every expected codepoint is out, then resumes
  task automatic test_drain_pause(input int n_bytes);
    test_random_text(n_bytes / 2);
    drain_results();
    test_random_text(n_bytes - n_bytes / 2);
  endtask

  initial begin
    byte_ch.valid       = 1'b0;
    byte_ch.byte_in     = 8'd0;
    byte_ch.end_of_text = 1'b0;
    cp_ch.ready         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_ascii_extremes();
    test_sequences();
    test_invalid_leads();
    test_broken_sequences();
    test_end_flush();
    test_random_text(80);
    test_output_hold(40);
    test_drain_pause(40);

    // let the pipe settle and catch any stray result
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && cp_expect.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
